/* src/itp_pkg.sv */
// shared codes, character constants and helper functions for the infix to postfix converter
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  typedef logic [2:0] code_t;
  typedef logic [1:0] prio_t;
  typedef logic [1:0] status_t;

  // operator codes as kept on the stack
  localparam code_t CODE_OPEN   = 3'd0;
  localparam code_t CODE_PLUS   = 3'd1;
  localparam code_t CODE_MINUS  = 3'd2;
  localparam code_t CODE_STAR   = 3'd3;
  localparam code_t CODE_SLASH  = 3'd4;
  localparam code_t CODE_PCT    = 3'd5;
  localparam code_t CODE_DOLLAR = 3'd6;

  // status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_BAD_CLOSE = 2'd2;
  localparam status_t ST_BAD_OPEN  = 2'd3;

  // ascii characters
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NUL    = 8'h00;

  function automatic logic is_alnum(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]};
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_DOLLAR};
  endfunction

  function automatic code_t op_code(logic [7:0] c);
    code_t r;
    case (c)
      CH_PLUS:   r = CODE_PLUS;
      CH_MINUS:  r = CODE_MINUS;
      CH_STAR:   r = CODE_STAR;
      CH_SLASH:  r = CODE_SLASH;
      CH_PCT:    r = CODE_PCT;
      CH_DOLLAR: r = CODE_DOLLAR;
      default:   r = CODE_OPEN;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(code_t k);
    logic [7:0] r;
    case (k)
      CODE_OPEN:   r = CH_LPAREN;
      CODE_PLUS:   r = CH_PLUS;
      CODE_MINUS:  r = CH_MINUS;
      CODE_STAR:   r = CH_STAR;
      CODE_SLASH:  r = CH_SLASH;
      CODE_PCT:    r = CH_PCT;
      CODE_DOLLAR: r = CH_DOLLAR;
      default:     r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic prio_t code_prio(code_t k);
    prio_t r;
    case (k)
      CODE_PLUS, CODE_MINUS:           r = 2'd1;
      CODE_STAR, CODE_SLASH, CODE_PCT: r = 2'd2;
      CODE_DOLLAR:                     r = 2'd3;
      default:                         r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

/* src/itp_stack.sv */
// operator stack storage: one write port, one registered read port
module itp_stack #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  itp_pkg::code_t      wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output itp_pkg::code_t      rd_data
);
  import itp_pkg::*;

  code_t mem [STACK_DEPTH];
  code_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/infix_to_postfix_converter.sv */
// top level of the shunting-yard infix to postfix converter
//
// usage:
//   input channel in_valid/in_ready carries one infix character per request
//   (in_char) or an end marker (in_is_end). result channel out_valid/out_ready
//   carries postfix characters (out_char with out_char_valid) and status
//   results; out_last marks the final result caused by one input request.
// timing:
//   a letter or digit is held, then moved into the output register once the
//   slot is free, and the next request is taken after that. a paren push is done in
//   the accept cycle, so the next request can follow right away.
//   every popped stack entry, open parens included, passes S_CHECK (pop) and
//   then S_LOAD (memory read to refill the cached top). a new request is taken
//   only once the one in work is finished, including any held character and
//   status result still to be sent.
// reset:
//   rst_n low clears the stack count, the sequencer and the output valid flag;
//   the stack memory itself is not cleared, and a value read from at or above
//   the count is never used.
// stall:
//   results sit in a one-entry output register; a stalled receiver holds the
//   sequencer, and input is taken again once the request in work is finished.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char,
  input  logic                in_is_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_char_valid,
  output itp_pkg::status_t    out_status,
  output logic                out_last
);
  import itp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);
  localparam logic [CW-1:0] TWO_CNT  = CW'(2);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_LOAD  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  // what the pop loop is doing
  localparam logic [1:0] M_END   = 2'd0;
  localparam logic [1:0] M_CLOSE = 2'd1;
  localparam logic [1:0] M_OP    = 2'd2;
  localparam logic [1:0] M_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  code_t         top_r, top_nxt;
  code_t         opc_r, opc_nxt;
  prio_t         oprio_r, oprio_nxt;
  logic          open_seen_r, open_seen_nxt;
  // popped or input character held back until we know whether it is the last result
  logic          pend_vld_r, pend_vld_nxt;
  logic [7:0]    pend_char_r, pend_char_nxt;
  // a status-only result closes the request
  logic          fin_r, fin_nxt;
  status_t       fin_status_r, fin_status_nxt;

  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_char_valid_r;
  status_t       out_status_r;
  logic          out_last_r;

  logic          out_load;
  logic [7:0]    out_char_d;
  logic          out_char_valid_d;
  status_t       out_status_d;
  logic          out_last_d;

  logic          wr_en;
  code_t         wr_data;
  logic          rd_en;
  code_t         rd_data;
  logic [CW-1:0] cnt_m2;
  logic          slot_free;
  logic          full;

  assign cnt_m2    = cnt_r - TWO_CNT;
  assign slot_free = !out_valid_r || out_ready;
  assign full      = (cnt_r == FULL_CNT);
  assign in_ready  = (state_r == S_IDLE);

  itp_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt_m2[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    cnt_nxt          = cnt_r;
    top_nxt          = top_r;
    opc_nxt          = opc_r;
    oprio_nxt        = oprio_r;
    open_seen_nxt    = open_seen_r;
    pend_vld_nxt     = pend_vld_r;
    pend_char_nxt    = pend_char_r;
    fin_nxt          = fin_r;
    fin_status_nxt   = fin_status_r;
    wr_en            = 1'b0;
    wr_data          = CODE_OPEN;
    rd_en            = 1'b0;
    out_load         = 1'b0;
    out_char_d       = pend_char_r;
    out_char_valid_d = 1'b1;
    out_status_d     = ST_OK;
    out_last_d       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          open_seen_nxt = 1'b0;
          pend_vld_nxt  = 1'b0;
          fin_nxt       = 1'b0;
          if (in_is_end) begin
            mode_nxt  = M_END;
            state_nxt = S_CHECK;
          end else if (is_alnum(in_char)) begin
            pend_vld_nxt  = 1'b1;
            pend_char_nxt = in_char;
            state_nxt     = S_FIN;
          end else if (in_char == CH_LPAREN) begin
            if (full) begin
              fin_nxt        = 1'b1;
              fin_status_nxt = ST_OVERFLOW;
              state_nxt      = S_FIN;
            end else begin
              wr_en   = 1'b1;
              wr_data = CODE_OPEN;
              top_nxt = CODE_OPEN;
              cnt_nxt = cnt_r + ONE_CNT;
            end
          end else if (in_char == CH_RPAREN) begin
            mode_nxt  = M_CLOSE;
            state_nxt = S_CHECK;
          end else if (is_op(in_char)) begin
            mode_nxt  = M_OP;
            opc_nxt   = op_code(in_char);
            oprio_nxt = code_prio(op_code(in_char));
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        if (mode_r == M_DONE) begin
          state_nxt = S_FIN;
        end else if (cnt_r == '0) begin
          // stack drained
          case (mode_r)
            M_END: begin
              fin_nxt        = 1'b1;
              fin_status_nxt = open_seen_r ? ST_BAD_OPEN : ST_OK;
            end
            M_CLOSE: begin
              fin_nxt        = 1'b1;
              fin_status_nxt = ST_BAD_CLOSE;
            end
            default: begin
              wr_en   = 1'b1;
              wr_data = opc_r;
              top_nxt = opc_r;
              cnt_nxt = cnt_r + ONE_CNT;
            end
          endcase
          state_nxt = S_FIN;
        end else if (mode_r == M_OP &&
                     (top_r == CODE_OPEN || code_prio(top_r) < oprio_r)) begin
          // pop loop stops here, push or overflow
          if (full) begin
            fin_nxt        = 1'b1;
            fin_status_nxt = ST_OVERFLOW;
          end else begin
            wr_en   = 1'b1;
            wr_data = opc_r;
            top_nxt = opc_r;
            cnt_nxt = cnt_r + ONE_CNT;
          end
          state_nxt = S_FIN;
        end else if (top_r == CODE_OPEN) begin
          // open paren: discarded, ends a close, noted by an end
          cnt_nxt   = cnt_r - ONE_CNT;
          rd_en     = 1'b1;
          state_nxt = S_LOAD;
          if (mode_r == M_CLOSE) begin
            mode_nxt = M_DONE;
          end else begin
            open_seen_nxt = 1'b1;
          end
        end else if (!pend_vld_r || slot_free) begin
          // pop an operator; the earlier held one is now known not last
          out_load      = pend_vld_r;
          pend_vld_nxt  = 1'b1;
          pend_char_nxt = code_char(top_r);
          cnt_nxt       = cnt_r - ONE_CNT;
          rd_en         = 1'b1;
          state_nxt     = S_LOAD;
        end
      end

      S_LOAD: begin
        top_nxt   = rd_data;
        state_nxt = S_CHECK;
      end

      S_FIN: begin
        if (pend_vld_r) begin
          if (slot_free) begin
            out_load     = 1'b1;
            out_last_d   = !fin_r;
            pend_vld_nxt = 1'b0;
            if (!fin_r) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (fin_r) begin
          if (slot_free) begin
            out_load         = 1'b1;
            out_char_d       = CH_NUL;
            out_char_valid_d = 1'b0;
            out_status_d     = fin_status_r;
            out_last_d       = 1'b1;
            fin_nxt          = 1'b0;
            state_nxt        = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_END;
      cnt_r       <= '0;
      open_seen_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      open_seen_r <= open_seen_nxt;
      pend_vld_r  <= pend_vld_nxt;
      fin_r       <= fin_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    opc_r        <= opc_nxt;
    oprio_r      <= oprio_nxt;
    pend_char_r  <= pend_char_nxt;
    fin_status_r <= fin_status_nxt;
    if (out_load) begin
      out_char_r       <= out_char_d;
      out_char_valid_r <= out_char_valid_d;
      out_status_r     <= out_status_d;
      out_last_r       <= out_last_d;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_char_valid_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule
